// ===== hdl/mig_pkg.sv =====
// Package for the modular inverse block: default word width, sequencer
// states and the status group passed from the core to the top level.
// Used by mig_core.sv and modular_inverse_gcd.sv; depends on nothing.
package mig_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int FIELD_BITS    = 64;

	typedef enum logic [2:0] {
		C_IDLE,
		C_ALIGN,
		C_SUB,
		C_FIX,
		C_DONE
	} core_state_t;

	typedef struct packed {
		logic ready;
		logic done;
	} core_status_t;

endpackage

// ===== hdl/modular_inverse_gcd.sv =====
// Top level of the extended Euclid modular inverse block.
// Depends on mig_pkg and instantiates mig_core.
//
// Usage: a word on the slave stream carries value in tdata[63:0] and modulus
// in tdata[127:64]. The block runs the extended Euclidean algorithm and sends
// one word on the master stream: cofactor in tdata[63:0], gcd in tdata[127:64]
// and order_error in tuser. When gcd is 1 the cofactor is the modular inverse.
// A modulus not above the value sets order_error with zero data fields.
// Only the low WORD_BITS bits of each input field are used.
// Each Euclid step runs the shift-subtract unit: it first shifts the divisor
// into alignment, then forms the quotient bit by bit. After the last step the
// core passes through C_FIX and C_DONE and m_axis_tvalid is set from the output
// register; a zero value goes straight to C_FIX and an order error straight to
// C_DONE. The next word is accepted in the cycle after the result leaves
// the core. One word is processed at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so a new word is accepted while it
// waits; a stalled receiver holds the next result inside the core.
// Reset clears all handshake state; no word is pending after reset.
module modular_inverse_gcd #(
	parameter int WORD_BITS = mig_pkg::WORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [2*mig_pkg::FIELD_BITS-1:0] s_axis_tdata,  // value, modulus
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [2*mig_pkg::FIELD_BITS-1:0] m_axis_tdata,  // cofactor, gcd
	output logic                           m_axis_tuser   // order_error
);

	localparam int FB = mig_pkg::FIELD_BITS;

	mig_pkg::core_status_t status;

	logic [WORD_BITS-1:0] core_cof;
	logic [WORD_BITS-1:0] core_gcd;
	logic                 core_err;
	logic                 start;
	logic                 take;

	logic                 m_valid_q;
	logic [2*FB-1:0]      m_data_q;
	logic                 m_user_q;

	assign start = s_axis_tvalid && status.ready;
	assign take  = status.done && (!m_valid_q || m_axis_tready);

	mig_core #(
		.WORD_BITS(WORD_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.ack        (take),
		.value      (s_axis_tdata[WORD_BITS-1:0]),
		.modulus    (s_axis_tdata[FB+WORD_BITS-1:FB]),
		.status     (status),
		.cofactor   (core_cof),
		.gcd        (core_gcd),
		.order_error(core_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (take)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_data_q <= {FB'(core_gcd), FB'(core_cof)};
			m_user_q <= core_err;
		end
	end

	assign s_axis_tready = status.ready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// ===== hdl/mig_core.sv =====
// Iterative extended Euclid core built around one shift-subtract unit.
// Depends on mig_pkg for its state type and status struct.
// Each quotient is formed bit by bit while the cofactor is updated alongside.
module mig_core #(
	parameter int WORD_BITS = mig_pkg::WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  ack,
	input  logic [WORD_BITS-1:0]  value,
	input  logic [WORD_BITS-1:0]  modulus,
	output mig_pkg::core_status_t status,
	output logic [WORD_BITS-1:0]  cofactor,
	output logic [WORD_BITS-1:0]  gcd,
	output logic                  order_error
);

	localparam int W  = WORD_BITS;
	localparam int KW = $clog2(W);

	mig_pkg::core_state_t state_q, state_next;

	logic [W-1:0]   rem_q;
	logic [W-1:0]   s_q;
	logic [W-1:0]   b_q;
	logic [W-1:0]   sb_q;
	logic [W-1:0]   d_q;
	logic [2*W-1:0] sd_q;
	logic [KW-1:0]  k_q;
	logic [W-1:0]   mod_q;
	logic [W-1:0]   cof_q;
	logic [W-1:0]   gcd_q;
	logic           err_q;

	logic           can_shift;
	logic           ge;
	logic [W-1:0]   rem_n;
	logic [W-1:0]   s_n;
	logic           bad_order;

	assign can_shift = !d_q[W-1] && ({d_q[W-2:0], 1'b0} <= rem_q);
	assign ge        = rem_q >= d_q;
	assign rem_n     = ge ? (rem_q - d_q) : rem_q;
	assign s_n       = ge ? (s_q - sd_q[W-1:0]) : s_q;
	assign bad_order = modulus <= value;

	always_comb begin
		state_next = state_q;
		case (state_q)
			mig_pkg::C_IDLE: begin
				if (start) begin
					if (bad_order || value == '0)
						state_next = bad_order ? mig_pkg::C_DONE : mig_pkg::C_FIX;
					else
						state_next = mig_pkg::C_ALIGN;
				end
			end
			mig_pkg::C_ALIGN: begin
				if (!can_shift)
					state_next = mig_pkg::C_SUB;
			end
			mig_pkg::C_SUB: begin
				if (k_q == '0)
					state_next = (rem_n == '0) ? mig_pkg::C_FIX : mig_pkg::C_ALIGN;
			end
			mig_pkg::C_FIX: state_next = mig_pkg::C_DONE;
			mig_pkg::C_DONE: begin
				if (ack)
					state_next = mig_pkg::C_IDLE;
			end
			default: state_next = mig_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		status.ready = (state_q == mig_pkg::C_IDLE);
		status.done  = (state_q == mig_pkg::C_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mig_pkg::C_IDLE;
		else
			state_q <= state_next;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mig_pkg::C_IDLE: begin
				if (start) begin
					mod_q <= modulus;
					rem_q <= modulus;
					s_q   <= '0;
					b_q   <= value;
					sb_q  <= W'(1);
					d_q   <= value;
					sd_q  <= (2*W)'(1);
					k_q   <= '0;
					err_q <= bad_order;
					cof_q <= '0;
					gcd_q <= '0;
				end
			end
			mig_pkg::C_ALIGN: begin
				if (can_shift) begin
					d_q  <= {d_q[W-2:0], 1'b0};
					sd_q <= {sd_q[2*W-2:0], 1'b0};
					k_q  <= k_q + 1'b1;
				end
			end
			mig_pkg::C_SUB: begin
				if (k_q == '0) begin
					// Quotient finished: rotate the remainder sequence.
					rem_q <= b_q;
					s_q   <= sb_q;
					b_q   <= rem_n;
					sb_q  <= s_n;
					d_q   <= rem_n;
					sd_q  <= {{W{1'b0}}, s_n};
				end else begin
					rem_q <= rem_n;
					s_q   <= s_n;
					d_q   <= {1'b0, d_q[W-1:1]};
					sd_q  <= {1'b0, sd_q[2*W-1:1]};
					k_q   <= k_q - 1'b1;
				end
			end
			mig_pkg::C_FIX: begin
				// A negative cofactor is brought back into the modulus range.
				cof_q <= s_q[W-1] ? (s_q + mod_q) : s_q;
				gcd_q <= rem_q;
			end
			default: begin
			end
		endcase
	end

	assign cofactor    = cof_q;
	assign gcd         = gcd_q;
	assign order_error = err_q;

endmodule
